// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL top level of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/tkrs_pkg.sv =====
// Package with the types and constants of the top-k roulette selection table.
`default_nettype none
package tkrs_pkg;
	localparam int TBL_DEPTH = 32;
	localparam int ID_W    = 16;
	localparam int SCORE_W = 32;
	localparam int PICK_W  = 32;
	localparam int PCT_W   = 7;
	localparam int CAP_W   = 6;
	localparam int OCNT_W  = 6;

	localparam logic [CAP_W-1:0] CAP_RESET    = 6'd32;
	localparam logic [PCT_W-1:0] CHANCE_RESET = 7'd10;

	localparam logic [0:0] CFG_CAPACITY = 1'b0;
	localparam logic [0:0] CFG_CHANCE   = 1'b1;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_SELECT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PUT,
		ST_EV_RD,
		ST_EV_SET,
		ST_BUB_RD,
		ST_BUB_CMP,
		ST_LOW_RD,
		ST_LOW_SET,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHF_RD,
		ST_SHF_WR,
		ST_RLOW_RD,
		ST_RLOW_SET,
		ST_DIV,
		ST_DIV_END,
		ST_MOD,
		ST_MOD_END,
		ST_MUL,
		ST_MUL_END,
		ST_WALK_RD,
		ST_WALK_CMP
	} state_t;

	typedef struct packed {
		func_t               func;
		logic [ID_W-1:0]     entry_id;
		logic [SCORE_W-1:0]  score;
		logic [PCT_W-1:0]    rand_pct;
		logic [PICK_W-1:0]   rand_pick;
	} cmd_t;

	typedef struct packed {
		logic                accepted;
		logic                evicted_valid;
		logic [ID_W-1:0]     evicted_id;
		logic                chose_random;
		logic [ID_W-1:0]     chosen_id;
		logic                found;
		logic [OCNT_W-1:0]   entry_count;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/core/tkrs_alu.sv =====
// Shared wide adder and subtractor with carry out.
`default_nettype none
module tkrs_alu #(
	parameter int W = 72
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic      [W-1:0] sum,
	output logic              carry
);
	logic [W:0] full;

	assign full  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + {{W{1'b0}}, sub};
	assign sum   = full[W-1:0];
	assign carry = full[W];
endmodule
`default_nettype wire

// ===== rtl/core/tkrs_store.sv =====
// Entry memory holding the score and id of each table slot, registered read.
`default_nettype none
module tkrs_store
	import tkrs_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [ADDR_W-1:0]  waddr,
	input  wire logic [SCORE_W-1:0] wsc,
	input  wire logic [ID_W-1:0]    wid,
	input  wire logic [ADDR_W-1:0]  raddr,
	output logic      [SCORE_W-1:0] rsc,
	output logic      [ID_W-1:0]    rid
);
	logic [SCORE_W-1:0] sc_mem [DEPTH];
	logic [ID_W-1:0]    id_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			sc_mem[waddr] <= wsc;
			id_mem[waddr] <= wid;
		end
	end

	always_ff @(posedge clk) begin
		rsc <= sc_mem[raddr];
		rid <= id_mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/top_k_table_roulette_select.sv =====
// Top level: sorted top-k table with roulette selection and its sequencer.
//
//  channel   direction  handshake          beat
//  command   in         start / busy       cmd (cmd_t)
//  result    out        done strobe        result (result_t)
//  config    in         cfg_we             cfg_index, cfg_data
//
// Insert, and remove, which searches, closes the gap and inserts again, keep
// busy high for a time bounded by the single read port of the entry memory. A
// roulette select runs the shared adder as a divider, a modulo and a multiplier
// as needed and then walks the table. Query and random select answer in the
// next cycle. Reset clears the state, count, sum, lowest score and done and
// loads the config defaults; the memory needs no clearing. Results cannot be
// stalled: done is high for one cycle with the beat.
`default_nettype none
`include "assert_macros.svh"
module top_k_table_roulette_select
	import tkrs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cmd_t             cmd,
	output logic                  done,
	output result_t               result,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [PCT_W-1:0] cfg_data
);
	localparam int CNT_W  = $clog2(TBL_DEPTH + 1);
	localparam int ADDR_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int SUM_W  = SCORE_W + CNT_W;
	localparam int NUM_W  = SUM_W + 2;
	localparam int AW     = NUM_W + SCORE_W;
	localparam int IT_W   = $clog2(AW + 1);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, pos_q, ecap, cntm1, posm1, posp1;
	logic [SUM_W-1:0]    sum_q;
	logic [SCORE_W-1:0]  low_q, mv_sc_q, rd_sc, wsc;
	logic [ID_W-1:0]     mv_id_q, id_q, rd_id, wid;
	logic [CAP_W-1:0]    cap_q;
	logic [PCT_W-1:0]    chance_q;
	logic [PICK_W-1:0]   pick_q;
	func_t               func_q;
	logic                done_q, fin, we, accept, room, beats, hit, shf_more, cont;
	logic                is_rand, q_acc, alu_sub, alu_c;
	logic [ADDR_W-1:0]   waddr, raddr;
	logic [AW-1:0]       rem_q, dq_q, den_q, alu_a, alu_b, alu_sum, trial_a;
	logic [SCORE_W-1:0]  mlt_q;
	logic [IT_W-1:0]     it_q;
	logic [NUM_W-1:0]    total;
	result_t             res_q;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign done    = done_q;
	assign result  = res_q;

	always_comb begin
		if (cap_q == '0) begin
			ecap = CNT_W'(1);
		end else if (32'(cap_q) > 32'(TBL_DEPTH)) begin
			ecap = CNT_W'(TBL_DEPTH);
		end else begin
			ecap = CNT_W'(cap_q);
		end
	end

	assign cntm1    = count_q - 1'b1;
	assign posm1    = pos_q - 1'b1;
	assign posp1    = pos_q + 1'b1;
	assign room     = count_q < ecap;
	assign beats    = (count_q != '0) && (mv_sc_q > low_q);
	assign q_acc    = room || ((count_q != '0) && (cmd.score > low_q));
	assign is_rand  = (cmd.rand_pct <= chance_q) || (count_q == '0);
	assign hit      = (rd_id == id_q);
	assign shf_more = posp1 < count_q;
	assign cont     = shf_more && (alu_sum < den_q);
	assign total    = dq_q[NUM_W-1:0];
	assign trial_a  = {rem_q[AW-2:0], dq_q[AW-1]};

	always_comb begin
		case (state_q)
			ST_DIV, ST_MOD: begin
				alu_a   = trial_a;
				alu_b   = den_q;
				alu_sub = 1'b1;
			end
			ST_MUL: begin
				alu_a   = rem_q;
				alu_b   = mlt_q[0] ? dq_q : '0;
				alu_sub = 1'b0;
			end
			default: begin
				alu_a   = rem_q;
				alu_b   = AW'(rd_sc);
				alu_sub = 1'b0;
			end
		endcase
	end

	tkrs_alu #(.W(AW)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_c)
	);

	tkrs_store #(.DEPTH(TBL_DEPTH), .ADDR_W(ADDR_W)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wsc   (wsc),
		.wid   (wid),
		.raddr (raddr),
		.rsc   (rd_sc),
		.rid   (rd_id)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FN_INSERT: state_d = ST_PUT;
						FN_REMOVE: state_d = ST_SRCH_RD;
						FN_SELECT: begin
							if (is_rand) begin
								state_d = ST_IDLE;
							end else if (low_q == '0) begin
								state_d = ST_WALK_RD;
							end else begin
								state_d = ST_DIV;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_PUT: begin
				if (room) begin
					state_d = ST_BUB_RD;
				end else if (beats) begin
					state_d = ST_EV_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EV_RD:   state_d = ST_EV_SET;
			ST_EV_SET:  state_d = ST_BUB_RD;
			ST_BUB_RD:  state_d = (pos_q == '0) ? ST_LOW_RD : ST_BUB_CMP;
			ST_BUB_CMP: state_d = (mv_sc_q > rd_sc) ? ST_BUB_RD : ST_LOW_RD;
			ST_LOW_RD:  state_d = ST_LOW_SET;
			ST_LOW_SET: state_d = ST_IDLE;
			ST_SRCH_RD: state_d = (pos_q == count_q) ? ST_IDLE : ST_SRCH_CMP;
			ST_SRCH_CMP: state_d = hit ? ST_SHF_RD : ST_SRCH_RD;
			ST_SHF_RD:  state_d = shf_more ? ST_SHF_WR : ST_RLOW_RD;
			ST_SHF_WR:  state_d = ST_SHF_RD;
			ST_RLOW_RD: state_d = ST_RLOW_SET;
			ST_RLOW_SET: state_d = ST_PUT;
			ST_DIV:     state_d = (it_q == IT_W'(NUM_W - 1)) ? ST_DIV_END : ST_DIV;
			ST_DIV_END: state_d = (total == '0) ? ST_WALK_RD : ST_MOD;
			ST_MOD:     state_d = (it_q == IT_W'(PICK_W - 1)) ? ST_MOD_END : ST_MOD;
			ST_MOD_END: state_d = ST_MUL;
			ST_MUL:     state_d = (it_q == IT_W'(SCORE_W - 1)) ? ST_MUL_END : ST_MUL;
			ST_MUL_END: state_d = ST_WALK_RD;
			ST_WALK_RD: state_d = ST_WALK_CMP;
			ST_WALK_CMP: state_d = cont ? ST_WALK_RD : ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[ADDR_W-1:0];
		wsc   = mv_sc_q;
		wid   = mv_id_q;
		raddr = pos_q[ADDR_W-1:0];
		fin   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && ((cmd.func == FN_QUERY) ||
						((cmd.func == FN_SELECT) && is_rand))) begin
					fin = 1'b1;
				end
			end
			ST_PUT: fin = !room && !beats;
			ST_EV_RD, ST_LOW_RD, ST_RLOW_RD: raddr = cntm1[ADDR_W-1:0];
			ST_BUB_RD: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					raddr = posm1[ADDR_W-1:0];
				end
			end
			ST_BUB_CMP: begin
				we = 1'b1;
				if (mv_sc_q > rd_sc) begin
					wsc = rd_sc;
					wid = rd_id;
				end
			end
			ST_LOW_SET: fin = 1'b1;
			ST_SRCH_RD: fin = (pos_q == count_q);
			ST_SHF_RD:  raddr = posp1[ADDR_W-1:0];
			ST_SHF_WR: begin
				we  = 1'b1;
				wsc = rd_sc;
				wid = rd_id;
			end
			ST_WALK_CMP: fin = !cont;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			sum_q    <= '0;
			low_q    <= '0;
			cap_q    <= CAP_RESET;
			chance_q <= CHANCE_RESET;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY: cap_q <= cfg_data[CAP_W-1:0];
					CFG_CHANCE:   chance_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_PUT: begin
					if (room) begin
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(mv_sc_q);
					end
				end
				ST_EV_SET:   sum_q <= sum_q - SUM_W'(low_q) + SUM_W'(mv_sc_q);
				ST_LOW_SET:  low_q <= rd_sc;
				ST_SRCH_CMP: begin
					if (hit) begin
						sum_q <= sum_q - SUM_W'(rd_sc);
					end
				end
				ST_SHF_RD: begin
					if (!shf_more) begin
						count_q <= count_q - 1'b1;
					end
				end
				ST_RLOW_SET: begin
					if (count_q != '0) begin
						low_q <= rd_sc;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q  <= cmd.func;
					id_q    <= cmd.entry_id;
					mv_id_q <= cmd.entry_id;
					mv_sc_q <= cmd.score;
					pick_q  <= cmd.rand_pick;
					pos_q   <= '0;
					it_q    <= '0;
					rem_q   <= '0;
					res_q   <= '{accepted: (cmd.func == FN_QUERY) && q_acc,
						evicted_valid: 1'b0, evicted_id: '0,
						chose_random: (cmd.func == FN_SELECT) && is_rand,
						chosen_id: '0, found: 1'b0,
						entry_count: OCNT_W'(count_q)};
					if (cmd.func == FN_SELECT) begin
						if (low_q == '0) begin
							den_q <= '0;
						end else begin
							den_q <= AW'({low_q, 1'b0});
							dq_q  <= {NUM_W'({sum_q, 1'b0}) + NUM_W'(low_q),
								{SCORE_W{1'b0}}};
						end
					end
				end
			end
			ST_PUT: begin
				if (room) begin
					pos_q <= count_q;
					res_q.accepted <= (func_q == FN_INSERT);
				end else if (!beats) begin
					res_q.evicted_valid <= 1'b1;
					res_q.evicted_id    <= mv_id_q;
					res_q.entry_count   <= OCNT_W'(count_q);
				end
			end
			ST_EV_SET: begin
				res_q.evicted_valid <= 1'b1;
				res_q.evicted_id    <= rd_id;
				res_q.accepted      <= (func_q == FN_INSERT);
				pos_q <= cntm1;
			end
			ST_BUB_CMP: begin
				if (mv_sc_q > rd_sc) begin
					pos_q <= posm1;
				end
			end
			ST_LOW_SET: res_q.entry_count <= OCNT_W'(count_q);
			ST_SRCH_RD: begin
				if (pos_q == count_q) begin
					res_q.entry_count <= OCNT_W'(count_q);
				end
			end
			ST_SRCH_CMP: begin
				if (hit) begin
					res_q.found <= 1'b1;
					mv_sc_q <= rd_sc >> 1;
				end else begin
					pos_q <= posp1;
				end
			end
			ST_SHF_WR: pos_q <= posp1;
			ST_DIV, ST_MOD: begin
				rem_q <= alu_c ? alu_sum : trial_a;
				dq_q  <= {dq_q[AW-2:0], alu_c};
				it_q  <= it_q + 1'b1;
			end
			ST_DIV_END: begin
				rem_q <= '0;
				it_q  <= '0;
				if (total == '0) begin
					den_q <= '0;
				end else begin
					den_q <= AW'(total);
					dq_q  <= {pick_q, {(AW - PICK_W){1'b0}}};
				end
			end
			ST_MOD_END: begin
				dq_q  <= rem_q;
				mlt_q <= low_q;
				rem_q <= '0;
				it_q  <= '0;
			end
			ST_MUL: begin
				rem_q <= alu_sum;
				dq_q  <= {dq_q[AW-2:0], 1'b0};
				mlt_q <= mlt_q >> 1;
				it_q  <= it_q + 1'b1;
			end
			ST_MUL_END: begin
				den_q <= rem_q;
				rem_q <= '0;
			end
			ST_WALK_CMP: begin
				if (cont) begin
					rem_q <= alu_sum;
					pos_q <= posp1;
				end else begin
					res_q.chosen_id   <= rd_id;
					res_q.entry_count <= OCNT_W'(count_q);
				end
			end
			default: ;
		endcase
	end

	`ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(TBL_DEPTH))
	`ASSERT_IMP(a_empty_sum, (state_q == ST_IDLE) && (count_q == '0), sum_q == '0)
	`ASSERT_IMP(a_bubble_pos, state_q == ST_BUB_CMP, pos_q != '0)
	`ASSERT_NXT(a_fin_done, fin, done && !busy)
endmodule
`default_nettype wire
